// ----- src/sawfr_pkg.sv -----
// Package for the stop-and-wait frame receiver.
// Holds the status codes, frame layout constants and the summary and result types.
// No dependencies.
`timescale 1ns / 1ps

package sawfr_pkg;

   localparam logic [7:0] MAX_FRAME      = 8'd200;
   localparam logic [7:0] MIN_FRAME      = 8'd7;
   localparam logic [8:0] OVERHEAD_BYTES = 9'd7;

   localparam logic [7:0] POS_TYPE    = 8'd0;
   localparam logic [7:0] POS_SEQ_LO  = 8'd1;
   localparam logic [7:0] POS_SEQ_HI  = 8'd2;
   localparam logic [7:0] POS_EOP     = 8'd3;
   localparam logic [7:0] POS_LENGTH  = 8'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [2:0] {
      ST_ACCEPT = 3'd0,
      ST_DUP    = 3'd1,
      ST_CHECK  = 3'd2,
      ST_TYPE   = 3'd3,
      ST_LENGTH = 3'd4
   } status_type;

   typedef struct packed {
      logic        size_bad;
      logic        check_bad;
      logic        len_bad;
      logic [7:0]  type_byte;
      logic [15:0] frame_seq;
      logic        end_of_packet;
      logic [7:0]  payload_length;
   } summary_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] frame_seq;
      logic        end_of_packet;
      logic [7:0]  payload_length;
      logic        send_ack;
   } result_type;

endpackage

// ----- src/stop_and_wait_frame_receiver.sv -----
// Stop-and-wait frame receiver: the top level.
// Uses sawfr_front, sawfr_queue, sawfr_back and sawfr_pkg.
// Takes one frame byte per cycle on req_ while req_tready is high and gives one
// status item per frame on rsp_, registered in the back end after the queue. The
// front end folds and captures each byte as it is taken; a two-entry summary
// queue lets the front keep taking bytes while the output is stalled, and
// req_tready drops only when the queue is full. The user must write the data type
// code register on csr_ only while no frame is in flight; unchecked by the block.
`timescale 1ns / 1ps

module stop_and_wait_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] frame_byte
   input  logic        req_tlast,    // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [2:0] status, [18:3] frame_seq,
                                     // [19] end_of_packet, [27:20] payload_length,
                                     // [28] send_ack, [31:29] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);
   import sawfr_pkg::*;

   logic [7:0]  type_code_ff, type_code_in;
   logic        push;
   summary_type push_data;
   summary_type head;
   logic        empty;
   logic        full;
   logic        pop;
   result_type  result;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;

   always_comb begin
      type_code_in = type_code_ff;
      if (csr_valid && csr_ready) begin
         type_code_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_code_ff <= '0;
      end else begin
         type_code_ff <= type_code_in;
      end
   end

   sawfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .frame_byte (req_tdata),
      .last_byte  (req_tlast),
      .push       (push),
      .push_data  (push_data)
   );

   sawfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   sawfr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .data_type_code (type_code_ff),
      .head           (head),
      .empty          (empty),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_data       (result)
   );

   assign rsp_tdata = {3'b000, result.send_ack, result.payload_length,
                       result.end_of_packet, result.frame_seq, result.status};

endmodule

// ----- src/sawfr_front.sv -----
// Front end: accepts frame bytes, folds the check lanes and captures header fields.
// Pushes one frame summary at each last byte. Depends on sawfr_pkg.
`timescale 1ns / 1ps

module sawfr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 in_ready,
   input  logic [7:0]           frame_byte,
   input  logic                 last_byte,
   output logic                 push,
   output sawfr_pkg::summary_type push_data
);
   import sawfr_pkg::*;

   logic [7:0]  pos_ff, pos_in, upd_pos;
   logic [7:0]  even_ff, even_in, upd_even;
   logic [7:0]  odd_ff, odd_in, upd_odd;
   logic [7:0]  type_ff, type_in, upd_type;
   logic [15:0] seq_ff, seq_in, upd_seq;
   logic        eop_ff, eop_in, upd_eop;
   logic [7:0]  len_ff, len_in, upd_len;
   logic        over_ff, over_in, upd_over;
   logic [7:0]  prev_ff, prev_in, upd_prev;
   logic        accept;
   logic        taken;
   logic [7:0]  pair_xor;

   assign accept   = in_valid & in_ready;
   assign taken    = pos_ff < MAX_FRAME;
   assign pair_xor = prev_ff ^ frame_byte;

   always_comb begin
      upd_pos  = pos_ff;
      upd_even = even_ff;
      upd_odd  = odd_ff;
      upd_type = type_ff;
      upd_seq  = seq_ff;
      upd_eop  = eop_ff;
      upd_len  = len_ff;
      upd_over = over_ff;
      upd_prev = prev_ff;
      if (!taken) begin
         upd_over = 1'b1;
      end else begin
         if (pos_ff[0] == 1'b0) begin
            upd_even = even_ff ^ frame_byte;
         end else begin
            upd_odd = odd_ff ^ frame_byte;
         end
         if (pos_ff == POS_TYPE) begin
            upd_type = frame_byte;
         end
         if (pos_ff == POS_SEQ_LO) begin
            upd_seq = {seq_ff[15:8], frame_byte};
         end
         if (pos_ff == POS_SEQ_HI) begin
            upd_seq = {frame_byte, seq_ff[7:0]};
         end
         if (pos_ff == POS_EOP) begin
            upd_eop = frame_byte != 8'd0;
         end
         if (pos_ff == POS_LENGTH) begin
            upd_len = frame_byte;
         end
         upd_prev = frame_byte;
         upd_pos  = pos_ff + 8'd1;
      end
   end

   always_comb begin
      push_data.size_bad       = upd_over | (upd_pos < MIN_FRAME);
      if (pos_ff[0] == 1'b0) begin
         push_data.check_bad = !((upd_even == pair_xor) && (upd_odd == pair_xor));
      end else begin
         push_data.check_bad = !((upd_even == 8'd0) && (upd_odd == 8'd0));
      end
      push_data.len_bad        = ({1'b0, upd_len} + OVERHEAD_BYTES) != {1'b0, upd_pos};
      push_data.type_byte      = upd_type;
      push_data.frame_seq      = upd_seq;
      push_data.end_of_packet  = upd_eop;
      push_data.payload_length = upd_len;
   end

   assign push = accept & last_byte;

   always_comb begin
      pos_in  = pos_ff;
      even_in = even_ff;
      odd_in  = odd_ff;
      type_in = type_ff;
      seq_in  = seq_ff;
      eop_in  = eop_ff;
      len_in  = len_ff;
      over_in = over_ff;
      prev_in = prev_ff;
      if (accept && last_byte) begin
         pos_in  = '0;
         even_in = '0;
         odd_in  = '0;
         type_in = '0;
         seq_in  = '0;
         eop_in  = 1'b0;
         len_in  = '0;
         over_in = 1'b0;
         prev_in = '0;
      end else if (accept) begin
         pos_in  = upd_pos;
         even_in = upd_even;
         odd_in  = upd_odd;
         type_in = upd_type;
         seq_in  = upd_seq;
         eop_in  = upd_eop;
         len_in  = upd_len;
         over_in = upd_over;
         prev_in = upd_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         even_ff <= '0;
         odd_ff  <= '0;
         type_ff <= '0;
         seq_ff  <= '0;
         eop_ff  <= 1'b0;
         len_ff  <= '0;
         over_ff <= 1'b0;
         prev_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         even_ff <= even_in;
         odd_ff  <= odd_in;
         type_ff <= type_in;
         seq_ff  <= seq_in;
         eop_ff  <= eop_in;
         len_ff  <= len_in;
         over_ff <= over_in;
         prev_ff <= prev_in;
      end
   end

endmodule

// ----- src/sawfr_queue.sv -----
// Two-entry queue of frame summaries between the front and back ends.
// Depends on sawfr_pkg.
`timescale 1ns / 1ps

module sawfr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sawfr_pkg::summary_type push_data,
   input  logic                   pop,
   output sawfr_pkg::summary_type head,
   output logic                   empty,
   output logic                   full
);
   import sawfr_pkg::*;

   summary_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;

   assign empty = count_ff == '0;
   assign full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

// ----- src/sawfr_back.sv -----
// Back end: grades each frame summary, tracks the expected sequence number
// and holds the status item for the output. Depends on sawfr_pkg.
`timescale 1ns / 1ps

module sawfr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             data_type_code,
   input  sawfr_pkg::summary_type head,
   input  logic                   empty,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sawfr_pkg::result_type  out_data
);
   import sawfr_pkg::*;

   logic [15:0] expected_ff, expected_in;
   logic        valid_ff, valid_in;
   result_type  result_ff, result_in;
   status_type  status;
   logic        load;

   assign load = !empty && (!valid_ff || out_ready);
   assign pop  = load;

   always_comb begin
      priority if (head.size_bad) begin
         status = ST_LENGTH;
      end else if (head.check_bad) begin
         status = ST_CHECK;
      end else if (head.type_byte != data_type_code) begin
         status = ST_TYPE;
      end else if (head.len_bad) begin
         status = ST_LENGTH;
      end else if (head.frame_seq == expected_ff) begin
         status = ST_ACCEPT;
      end else begin
         status = ST_DUP;
      end
   end

   always_comb begin
      result_in.status         = status;
      result_in.frame_seq      = head.frame_seq;
      result_in.end_of_packet  = head.end_of_packet;
      result_in.payload_length = head.payload_length;
      result_in.send_ack       = (status == ST_ACCEPT) || (status == ST_DUP);
   end

   always_comb begin
      expected_in = expected_ff;
      valid_in    = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         if (status == ST_ACCEPT) begin
            expected_in = expected_ff + 16'd1;
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         expected_ff <= expected_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = result_ff;

`ifndef SYNTHESIS
   a_ack_match: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_data.send_ack ==
         ((out_data.status == ST_ACCEPT) || (out_data.status == ST_DUP))))
      else $error("send_ack disagrees with status");
   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      (load && (status == ST_ACCEPT)) |=> expected_ff == $past(expected_ff) + 16'd1)
      else $error("expected sequence did not advance");
   a_size_length: assert property (@(posedge clock) disable iff (reset)
      (load && head.size_bad) |=> out_data.status == ST_LENGTH)
      else $error("short or long frame not graded as bad length");
`endif

endmodule
